FILE: hdl/hsa_pkg.sv
// shared constants, types and helpers for the hsl saturation adjust pipeline
package hsa_pkg;

    localparam int C_CH_W       = 16;
    localparam int C_MAX_BITS   = 16;
    localparam int C_GAIN_W     = 10;
    localparam int C_BITS_W     = 5;
    localparam int C_CFG_IDX_W  = 2;
    localparam int C_SUM_W      = C_CH_W + 1;
    localparam int C_RATIO_W    = 18;
    localparam int C_REM_W      = C_CH_W + 1;
    localparam int C_PROD_W     = C_RATIO_W + C_CH_W;
    localparam int C_QBITS_STG  = 2;
    localparam int C_DIV_STG    = C_RATIO_W / C_QBITS_STG;
    localparam int C_MUL_W      = C_RATIO_W + C_RATIO_W + 1;
    localparam int C_NUM_W      = C_MUL_W + 2;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_BITS = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_GAIN = 2'd1;

    localparam logic [C_GAIN_W-1:0] C_GAIN_LIMIT = 10'd768;
    localparam logic [C_BITS_W-1:0] C_BITS_RESET = 5'd8;
    localparam logic [C_GAIN_W-1:0] C_GAIN_RESET = 10'd256;

    typedef logic [C_CH_W-1:0] t_ch;

    typedef struct packed {
        t_ch               r;
        t_ch               g;
        t_ch               b;
        logic [C_SUM_W-1:0] sum;
        t_ch               maxc;
        logic              gray;
        logic              frame;
    } t_pix;

    // 2c - sum as a signed value
    function automatic logic signed [C_RATIO_W-1:0] chan_off(t_ch c, logic [C_SUM_W-1:0] s);
        chan_off = $signed({1'b0, c, 1'b0}) - $signed({1'b0, s});
    endfunction

endpackage

FILE: hdl/hsl_saturation_adjust.sv
// top level: pipelined hsl saturation scaling of one rgb pixel per transfer
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  pixel in| i_in_valid/o_in_ready, i_red_in..i_frame_end_in | in
//  pixel out| o_out_valid/i_out_ready, o_red_out..o_frame_end_out | out
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data                | in
//
// one pixel per cycle sustained while the output is not stalled; the depth is set by the
// ratio divider, which resolves two quotient bits in each of nine stages.
// synchronous active-low reset clears the valid bits and loads the config registers with their defaults.
// a stall at the output freezes the whole pipeline; when the last stage is
// empty the pipeline keeps moving, so bubbles fill in.
module hsl_saturation_adjust #(
    parameter int MAX_BITS = hsa_pkg::C_MAX_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hsa_pkg::C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hsa_pkg::C_GAIN_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [hsa_pkg::C_CH_W-1:0]    i_red_in,
    input  logic [hsa_pkg::C_CH_W-1:0]    i_green_in,
    input  logic [hsa_pkg::C_CH_W-1:0]    i_blue_in,
    input  logic                          i_frame_end_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hsa_pkg::C_CH_W-1:0]    o_red_out,
    output logic [hsa_pkg::C_CH_W-1:0]    o_green_out,
    output logic [hsa_pkg::C_CH_W-1:0]    o_blue_out,
    output logic                          o_frame_end_out
);
    import hsa_pkg::*;

    localparam int NSTG = C_DIV_STG + 5;
    localparam logic [C_BITS_W-1:0] BITS_TOP = C_BITS_W'(MAX_BITS);

    logic [C_BITS_W-1:0] r_bits;
    logic [C_GAIN_W-1:0] r_gain;
    logic [NSTG-1:0]     r_vld;
    logic                en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= C_BITS_RESET;
            r_gain <= C_GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                C_REG_BITS: r_bits <= i_cfg_data[C_BITS_W-1:0];
                C_REG_GAIN: r_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[NSTG-2:0], i_in_valid};
    end

    // stage 0: depth clamp and sample masking
    logic [C_BITS_W-1:0] bits_c;
    t_ch                 maxc_c;
    t_pix                r_p0;
    always_comb begin
        bits_c = r_bits;
        if (bits_c == '0) bits_c = C_BITS_W'(1);
        if (bits_c > BITS_TOP) bits_c = BITS_TOP;
        maxc_c = C_CH_W'((C_SUM_W'(1) << bits_c) - C_SUM_W'(1));
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0.r     <= i_red_in & maxc_c;
            r_p0.g     <= i_green_in & maxc_c;
            r_p0.b     <= i_blue_in & maxc_c;
            r_p0.sum   <= '0;
            r_p0.maxc  <= maxc_c;
            r_p0.gray  <= 1'b0;
            r_p0.frame <= i_frame_end_in;
        end
    end

    // stage 1: max, min, chroma, denominator, clamped gain
    t_ch  mx, mn, den_c;
    logic [C_SUM_W-1:0] sum_c;
    logic [C_GAIN_W-1:0] gain_c;
    t_pix p1_c;
    t_pix r_p1;
    t_ch  r_d1, r_den1;
    logic [C_RATIO_W-1:0] r_g1;
    always_comb begin
        mx = r_p0.r;
        mn = r_p0.r;
        if (r_p0.g > mx) mx = r_p0.g;
        if (r_p0.b > mx) mx = r_p0.b;
        if (r_p0.g < mn) mn = r_p0.g;
        if (r_p0.b < mn) mn = r_p0.b;
        sum_c = {1'b0, mx} + {1'b0, mn};
        if (sum_c <= {1'b0, r_p0.maxc}) den_c = sum_c[C_CH_W-1:0];
        else den_c = C_CH_W'({r_p0.maxc, 1'b0} - sum_c);
        gain_c = (r_gain > C_GAIN_LIMIT) ? C_GAIN_LIMIT : r_gain;
        p1_c      = r_p0;
        p1_c.sum  = sum_c;
        p1_c.gray = (mx == mn);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1      <= p1_c;
            r_d1      <= mx - mn;
            r_den1    <= den_c;
            r_g1      <= {gain_c, 8'd0};
        end
    end

    // stage 2: gain times chroma for the limit test, divider set-up
    t_pix r_p2;
    t_ch  r_d2, r_den2;
    logic [C_RATIO_W-1:0] r_g2;
    logic [C_PROD_W-1:0]  r_prod2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2    <= r_p1;
            r_d2    <= r_d1;
            r_den2  <= r_den1;
            r_g2    <= r_g1;
            r_prod2 <= C_PROD_W'(r_g1 * r_d1);
        end
    end

    // divider stages: restoring division of den << 16 by d, two bits each
    t_pix                 r_pd  [C_DIV_STG];
    t_ch                  r_dd  [C_DIV_STG];
    logic [C_RATIO_W-1:0] r_gd  [C_DIV_STG];
    logic [C_REM_W-1:0]   r_rem [C_DIV_STG];
    logic [C_RATIO_W-1:0] r_nb  [C_DIV_STG];
    logic [C_RATIO_W-1:0] r_q   [C_DIV_STG];
    logic                 r_ovf [C_DIV_STG];

    t_pix                 s_p   [C_DIV_STG];
    t_ch                  s_d   [C_DIV_STG];
    logic [C_RATIO_W-1:0] s_g   [C_DIV_STG];
    logic [C_REM_W-1:0]   s_rem [C_DIV_STG];
    logic [C_RATIO_W-1:0] s_nb  [C_DIV_STG];
    logic [C_RATIO_W-1:0] s_q   [C_DIV_STG];
    logic                 s_ovf [C_DIV_STG];
    logic [C_REM_W-1:0]   n_rem [C_DIV_STG];
    logic [C_RATIO_W-1:0] n_q   [C_DIV_STG];

    always_comb begin
        logic [C_REM_W:0] sh;
        logic [C_REM_W-1:0] rm;
        logic [C_RATIO_W-1:0] qq;
        for (int k = 0; k < C_DIV_STG; k++) begin
            if (k == 0) begin
                s_p[k]   = r_p2;
                s_d[k]   = r_d2;
                s_g[k]   = r_g2;
                s_rem[k] = C_REM_W'(r_den2[C_CH_W-1:2]);
                s_nb[k]  = {r_den2[1:0], 16'd0};
                s_q[k]   = '0;
                // quotient at or above the gain term: gain wins
                s_ovf[k] = {2'b00, r_den2, 16'd0} >= r_prod2;
            end else begin
                s_p[k]   = r_pd[k-1];
                s_d[k]   = r_dd[k-1];
                s_g[k]   = r_gd[k-1];
                s_rem[k] = r_rem[k-1];
                s_nb[k]  = r_nb[k-1];
                s_q[k]   = r_q[k-1];
                s_ovf[k] = r_ovf[k-1];
            end
            rm = s_rem[k];
            qq = s_q[k];
            for (int j = 0; j < C_QBITS_STG; j++) begin
                sh = {rm, s_nb[k][C_RATIO_W-1-j]};
                if (sh >= {2'b00, s_d[k]}) begin
                    sh = sh - {2'b00, s_d[k]};
                    qq = {qq[C_RATIO_W-2:0], 1'b1};
                end else begin
                    qq = {qq[C_RATIO_W-2:0], 1'b0};
                end
                rm = sh[C_REM_W-1:0];
            end
            n_rem[k] = rm;
            n_q[k]   = qq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < C_DIV_STG; k++) begin
                r_pd[k]  <= s_p[k];
                r_dd[k]  <= s_d[k];
                r_gd[k]  <= s_g[k];
                r_rem[k] <= n_rem[k];
                r_nb[k]  <= {s_nb[k][C_RATIO_W-1-C_QBITS_STG:0], C_QBITS_STG'(0)};
                r_q[k]   <= n_q[k];
                r_ovf[k] <= s_ovf[k];
            end
        end
    end

    // ratio select and channel offset products
    logic [C_RATIO_W-1:0] ratio_c;
    t_pix r_pm;
    logic signed [C_MUL_W-1:0] r_mr, r_mg, r_mb;
    assign ratio_c = r_ovf[C_DIV_STG-1] ? r_gd[C_DIV_STG-1] : r_q[C_DIV_STG-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pm <= r_pd[C_DIV_STG-1];
            r_mr <= chan_off(r_pd[C_DIV_STG-1].r, r_pd[C_DIV_STG-1].sum)
                    * $signed({1'b0, ratio_c});
            r_mg <= chan_off(r_pd[C_DIV_STG-1].g, r_pd[C_DIV_STG-1].sum)
                    * $signed({1'b0, ratio_c});
            r_mb <= chan_off(r_pd[C_DIV_STG-1].b, r_pd[C_DIV_STG-1].sum)
                    * $signed({1'b0, ratio_c});
        end
    end

    // output stage: rounding, clamp, gray pass-through
    function automatic t_ch finish(logic signed [C_MUL_W-1:0] m, t_pix p, t_ch c);
        logic signed [C_NUM_W-1:0] num;
        logic [C_NUM_W-1:0] q;
        num = $signed({{(C_NUM_W-C_SUM_W-16){1'b0}}, p.sum, 16'd0})
            + C_NUM_W'(m) + $signed(C_NUM_W'(65536));
        q = C_NUM_W'(num >>> 17);
        if (p.gray) finish = c;
        else if (num < 0) finish = '0;
        else if (q > C_NUM_W'(p.maxc)) finish = p.maxc;
        else finish = q[C_CH_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_red_out       <= finish(r_mr, r_pm, r_pm.r);
            o_green_out     <= finish(r_mg, r_pm, r_pm.g);
            o_blue_out      <= finish(r_mb, r_pm, r_pm.b);
            o_frame_end_out <= r_pm.frame;
        end
    end

endmodule
